FILE: rtl/pcrp_pkg.sv
// ----------------------------------------------------------------------------
// pcrp_pkg
// shared constants, codes and control types of the per-channel requantizer
// ----------------------------------------------------------------------------
package pcrp_pkg;

  localparam int MAX_CHANNELS = 16;
  localparam int ACC_WIDTH    = 32;
  localparam int MULT_WIDTH   = 32;

  localparam int CH_W      = $clog2(MAX_CHANNELS);
  localparam int CH_CNT_W  = 5;
  localparam int POS_W     = 22;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 22;
  localparam int VAL_W     = 64;

  localparam logic signed [VAL_W-1:0] SAT_MAX = 64'sd127;
  localparam logic signed [VAL_W-1:0] SAT_MIN = -64'sd128;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_PROCESS = 1'b1;

  localparam logic [1:0] RND_FLOOR   = 2'd0;
  localparam logic [1:0] RND_NEAREST = 2'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT = 3'd0,
    REG_POSITIONS     = 3'd1,
    REG_ROUND_MODE    = 3'd2,
    REG_PRELU_ENABLE  = 3'd3,
    REG_PRELU_FIRST   = 3'd4,
    REG_SATURATE      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [CH_CNT_W-1:0] channel_count;
    logic [POS_W-1:0]    positions_per_frame;
    logic [1:0]          round_mode;
    logic                prelu_enable;
    logic                prelu_first;
    logic                saturate_enable;
  } cfg_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_SUM,
    OP_RND_MAG,
    OP_RND_SHIFT,
    OP_ADD_ZP
  } dp_op_t;

  typedef struct packed {
    logic   capture;
    logic   load;
    logic   use_prelu;
    dp_op_t op;
    logic   out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic val_neg;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/pcrp_if.sv
// ----------------------------------------------------------------------------
// pcrp_if
// valid/ready channels for input items and results
// ----------------------------------------------------------------------------
interface pcrp_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [3:0]         table_channel;
  logic signed [31:0] accumulator;
  logic signed [31:0] scale_multiplier;
  logic [5:0]         scale_shift;
  logic signed [7:0]  zero_offset;
  logic signed [31:0] slope_multiplier;
  logic [5:0]         slope_shift;

  modport source (
    output valid, command, table_channel, accumulator, scale_multiplier,
           scale_shift, zero_offset, slope_multiplier, slope_shift,
    input  ready
  );
  modport sink (
    input  valid, command, table_channel, accumulator, scale_multiplier,
           scale_shift, zero_offset, slope_multiplier, slope_shift,
    output ready
  );
endinterface

interface pcrp_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] activation;
  logic [3:0]        out_channel;
  logic              frame_last;

  modport source (
    output valid, activation, out_channel, frame_last,
    input  ready
  );
  modport sink (
    input  valid, activation, out_channel, frame_last,
    output ready
  );
endinterface

FILE: rtl/pcrp_cfg_regs.sv
// ----------------------------------------------------------------------------
// pcrp_cfg_regs
// configuration register file, write only
// ----------------------------------------------------------------------------
module pcrp_cfg_regs
  import pcrp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_count       <= CH_CNT_W'(16);
      cfg.positions_per_frame <= POS_W'(1);
      cfg.round_mode          <= RND_FLOOR;
      cfg.prelu_enable        <= 1'b0;
      cfg.prelu_first         <= 1'b0;
      cfg.saturate_enable     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CHANNEL_COUNT: cfg.channel_count       <= cfg_data[CH_CNT_W-1:0];
        REG_POSITIONS:     cfg.positions_per_frame <= cfg_data[POS_W-1:0];
        REG_ROUND_MODE:    cfg.round_mode          <= cfg_data[1:0];
        REG_PRELU_ENABLE:  cfg.prelu_enable        <= cfg_data[0];
        REG_PRELU_FIRST:   cfg.prelu_first         <= cfg_data[0];
        REG_SATURATE:      cfg.saturate_enable     <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/pcrp_ctrl.sv
// ----------------------------------------------------------------------------
// pcrp_ctrl
// sequencer: walks one item through its scaling passes
// ----------------------------------------------------------------------------
module pcrp_ctrl
  import pcrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_command,
  input  cfg_t       cfg,
  input  dp_status_t status,
  output logic       in_ready,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK_PRE,
    S_MUL_LO,
    S_MUL_HI,
    S_SUM,
    S_RND_MAG,
    S_RND_SHIFT,
    S_ADD_ZP,
    S_CHECK_POST,
    S_OUTPUT
  } state_t;

  typedef enum logic [1:0] {
    PASS_PRE,
    PASS_REQ,
    PASS_POST
  } pass_t;

  state_t state;
  pass_t  pass;
  logic   take;

  assign in_ready = (state == S_IDLE);
  assign take     = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    cmd.op        = OP_IDLE;
    cmd.use_prelu = (pass != PASS_REQ);
    case (state)
      S_IDLE: begin
        cmd.capture = take && (in_command == CMD_PROCESS);
        cmd.load    = take && (in_command == CMD_LOAD);
      end
      S_MUL_LO:    cmd.op = OP_MUL_LO;
      S_MUL_HI:    cmd.op = OP_MUL_HI;
      S_SUM:       cmd.op = OP_SUM;
      S_RND_MAG:   cmd.op = OP_RND_MAG;
      S_RND_SHIFT: cmd.op = OP_RND_SHIFT;
      S_ADD_ZP:    cmd.op = OP_ADD_ZP;
      S_OUTPUT:    cmd.out_load = status.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pass  <= PASS_REQ;
    end else begin
      case (state)
        S_IDLE: begin
          if (take && (in_command == CMD_PROCESS)) begin
            state <= S_CHECK_PRE;
          end
        end
        S_CHECK_PRE: begin
          state <= S_MUL_LO;
          if (cfg.prelu_enable && cfg.prelu_first && status.val_neg) begin
            pass <= PASS_PRE;
          end else begin
            pass <= PASS_REQ;
          end
        end
        S_MUL_LO:  state <= S_MUL_HI;
        S_MUL_HI:  state <= S_SUM;
        S_SUM:     state <= S_RND_MAG;
        S_RND_MAG: state <= S_RND_SHIFT;
        S_RND_SHIFT: begin
          case (pass)
            PASS_PRE: begin
              pass  <= PASS_REQ;
              state <= S_MUL_LO;
            end
            PASS_REQ:  state <= S_ADD_ZP;
            default:   state <= S_OUTPUT;
          endcase
        end
        S_ADD_ZP: state <= S_CHECK_POST;
        S_CHECK_POST: begin
          if (cfg.prelu_enable && !cfg.prelu_first && status.val_neg) begin
            pass  <= PASS_POST;
            state <= S_MUL_LO;
          end else begin
            state <= S_OUTPUT;
          end
        end
        S_OUTPUT: begin
          if (status.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/pcrp_datapath.sv
// ----------------------------------------------------------------------------
// pcrp_datapath
// channel tables, counters, shared multiplier, rounding shifter, output reg
// ----------------------------------------------------------------------------
module pcrp_datapath
  import pcrp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  ctrl_cmd_t          cmd,
  output dp_status_t         status,
  input  logic [3:0]         table_channel,
  input  logic signed [31:0] accumulator,
  input  logic signed [31:0] scale_multiplier,
  input  logic [5:0]         scale_shift,
  input  logic signed [7:0]  zero_offset,
  input  logic signed [31:0] slope_multiplier,
  input  logic [5:0]         slope_shift,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [7:0]  activation,
  output logic [3:0]         out_channel,
  output logic               frame_last
);

  // channel tables
  logic [MULT_WIDTH-1:0] rq_mult_mem [MAX_CHANNELS];
  logic [5:0]            rq_shift_mem [MAX_CHANNELS];
  logic [7:0]            zp_mem [MAX_CHANNELS];
  logic [MULT_WIDTH-1:0] pr_mult_mem [MAX_CHANNELS];
  logic [5:0]            pr_shift_mem [MAX_CHANNELS];

  // counters
  logic [CH_W-1:0]  channel_counter;
  logic [POS_W-1:0] position_counter;

  // item registers
  logic [MULT_WIDTH-1:0]   rq_mult;
  logic [5:0]              rq_shift;
  logic [7:0]              zp;
  logic [MULT_WIDTH-1:0]   pr_mult;
  logic [5:0]              pr_shift;
  logic [CH_W-1:0]         item_ch;
  logic                    item_last;
  logic signed [VAL_W-1:0] val;
  logic [VAL_W-1:0]        plo;
  logic [31:0]             phi;
  logic [VAL_W-1:0]        mag;
  logic                    rneg;

  // channel and position bookkeeping
  logic [CH_CNT_W-1:0] nch;
  logic [CH_CNT_W-1:0] ch_cur;
  logic                last_ch;
  logic [POS_W-1:0]    npos;
  logic [POS_W-1:0]    pos_cur;
  logic                last_pos;

  // arithmetic
  logic [MULT_WIDTH-1:0]   sel_mult;
  logic [5:0]              sel_shift;
  logic signed [32:0]      mul_a;
  logic signed [32:0]      mul_b;
  logic signed [65:0]      product;
  logic [VAL_W-1:0]        abs_val;
  logic [VAL_W-1:0]        round_inc;
  logic [VAL_W-1:0]        mag_sh;
  logic signed [7:0]       sat_val;

  always_comb begin
    if (cfg.channel_count == '0) begin
      nch = CH_CNT_W'(1);
    end else if (cfg.channel_count > CH_CNT_W'(MAX_CHANNELS)) begin
      nch = CH_CNT_W'(MAX_CHANNELS);
    end else begin
      nch = cfg.channel_count;
    end
    if ({1'b0, channel_counter} >= nch) begin
      ch_cur = nch - CH_CNT_W'(1);
    end else begin
      ch_cur = {1'b0, channel_counter};
    end
    last_ch = (ch_cur + CH_CNT_W'(1)) >= nch;

    npos = (cfg.positions_per_frame == '0) ? POS_W'(1) : cfg.positions_per_frame;
    pos_cur = (position_counter >= npos) ? (npos - POS_W'(1)) : position_counter;
    last_pos = ({1'b0, pos_cur} + (POS_W+1)'(1)) >= {1'b0, npos};
  end

  // shared multiplier: low word then high word of the 64-bit operand
  assign sel_mult  = cmd.use_prelu ? pr_mult : rq_mult;
  assign sel_shift = cmd.use_prelu ? pr_shift : rq_shift;
  assign mul_b     = 33'(signed'(sel_mult));
  assign mul_a     = (cmd.op == OP_MUL_HI) ? {val[63], val[63:32]} : {1'b0, val[31:0]};
  assign product   = mul_a * mul_b;

  assign abs_val   = val[63] ? (64'd0 - val) : val;
  assign round_inc = ((sel_shift != 6'd0) && (cfg.round_mode == RND_NEAREST))
                     ? (64'd1 << (sel_shift - 6'd1)) : 64'd0;
  assign mag_sh    = mag >> sel_shift;

  always_comb begin
    if (cfg.saturate_enable && !val[63] && (val > SAT_MAX)) begin
      sat_val = 8'sd127;
    end else if (cfg.saturate_enable && val[63] && (val < SAT_MIN)) begin
      sat_val = -8'sd128;
    end else begin
      sat_val = val[7:0];
    end
  end

  // table writes
  always_ff @(posedge clk) begin
    if (cmd.load && (32'(table_channel) < MAX_CHANNELS)) begin
      rq_mult_mem[table_channel[CH_W-1:0]]  <= scale_multiplier[MULT_WIDTH-1:0];
      rq_shift_mem[table_channel[CH_W-1:0]] <= scale_shift;
      zp_mem[table_channel[CH_W-1:0]]       <= zero_offset;
      pr_mult_mem[table_channel[CH_W-1:0]]  <= slope_multiplier[MULT_WIDTH-1:0];
      pr_shift_mem[table_channel[CH_W-1:0]] <= slope_shift;
    end
  end

  // counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_counter  <= '0;
      position_counter <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cmd.capture) begin
        if (last_ch) begin
          channel_counter  <= '0;
          position_counter <= last_pos ? '0 : (pos_cur + POS_W'(1));
        end else begin
          channel_counter  <= ch_cur[CH_W-1:0] + CH_W'(1);
          position_counter <= pos_cur;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rq_mult   <= rq_mult_mem[ch_cur[CH_W-1:0]];
      rq_shift  <= rq_shift_mem[ch_cur[CH_W-1:0]];
      zp        <= zp_mem[ch_cur[CH_W-1:0]];
      pr_mult   <= pr_mult_mem[ch_cur[CH_W-1:0]];
      pr_shift  <= pr_shift_mem[ch_cur[CH_W-1:0]];
      item_ch   <= ch_cur[CH_W-1:0];
      item_last <= last_ch && last_pos;
      val       <= VAL_W'(signed'(accumulator[ACC_WIDTH-1:0]));
    end
    case (cmd.op)
      OP_MUL_LO: plo <= product[VAL_W-1:0];
      OP_MUL_HI: phi <= product[31:0];
      OP_SUM:    val <= plo + {phi, 32'd0};
      OP_RND_MAG: begin
        rneg <= val[63];
        mag  <= abs_val + round_inc;
      end
      OP_RND_SHIFT: begin
        if (sel_shift == 6'd0) begin
          val <= val;
        end else if (cfg.round_mode == RND_FLOOR) begin
          val <= val >>> sel_shift;
        end else begin
          val <= rneg ? (64'd0 - mag_sh) : mag_sh;
        end
      end
      OP_ADD_ZP: val <= val + VAL_W'(signed'(zp));
      default: ;
    endcase
    if (cmd.out_load) begin
      activation  <= sat_val;
      out_channel <= 4'(item_ch);
      frame_last  <= item_last;
    end
  end

  assign status.val_neg  = val[63];
  assign status.out_free = !out_valid || out_ready;

endmodule

FILE: rtl/per_channel_requantize_prelu.sv
// ----------------------------------------------------------------------------
// per_channel_requantize_prelu
// int8 per-channel requantizer with optional prelu on negative values
// ----------------------------------------------------------------------------
// a load item (command 0) writes one channel's table entry and gives no
// result. a process item (command 1) runs one scaling pass on its way to the
// result register, and a prelu pass as well when one runs on a negative value;
// each scaling pass uses a single 33x33 multiplier that forms the 64-bit
// wrapping product in two halves (low word, high word, sum) and then a
// rounding shift (magnitude with rounding increment, then shift and sign
// restore). one item is worked at a time. the result register lets the next
// item transfer in while a finished result waits on the output. the channel
// counter cycles through channel_count and frame_last marks the last channel
// of the last position. table entries must be loaded before a process item
// reads them.
module per_channel_requantize_prelu
  import pcrp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  pcrp_in_if.sink               in_ch,
  pcrp_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  // configuration registers
  pcrp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer
  pcrp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .cfg        (cfg),
    .status     (status),
    .in_ready   (in_ready),
    .cmd        (cmd)
  );

  assign in_ch.ready = in_ready;

  // tables, counters, arithmetic and result register
  pcrp_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .cmd              (cmd),
    .status           (status),
    .table_channel    (in_ch.table_channel),
    .accumulator      (in_ch.accumulator),
    .scale_multiplier (in_ch.scale_multiplier),
    .scale_shift      (in_ch.scale_shift),
    .zero_offset      (in_ch.zero_offset),
    .slope_multiplier (in_ch.slope_multiplier),
    .slope_shift      (in_ch.slope_shift),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .activation       (out_ch.activation),
    .out_channel      (out_ch.out_channel),
    .frame_last       (out_ch.frame_last)
  );

endmodule

FILE: tb/sv/per_channel_requantize_prelu_tb.sv
// ----------------------------------------------------------------------------
// per_channel_requantize_prelu_tb
// self-checking bench: random table loads and accumulators are streamed into
// the requantizer across several register settings, and every int8 result is
// compared with a cycle-free prediction of the per-channel math
// ----------------------------------------------------------------------------
module per_channel_requantize_prelu_tb;
  import pcrp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int DRAIN_CYCLES    = 20;    // covers the longest item plus idle return
  localparam int LONG_HOLD       = 400;   // receiver hold-off that backs up the input
  localparam int IDLE_LIMIT      = 3000;  // cycles without any transfer before giving up
  localparam int REPORT_CAP      = 100;

  // one input item as it crosses the input channel
  typedef struct {
    logic               command;
    logic [3:0]         table_channel;
    logic signed [31:0] accumulator;
    logic signed [31:0] scale_multiplier;
    logic [5:0]         scale_shift;
    logic signed [7:0]  zero_offset;
    logic signed [31:0] slope_multiplier;
    logic [5:0]         slope_shift;
  } pcrp_item_t;

  // one predicted activation
  typedef struct {
    logic signed [7:0] activation;
    logic [3:0]        channel;
    logic              last;
  } act_t;

  // --------------------------------------------------------------------------
  // predictor and result store
  // --------------------------------------------------------------------------
  class requant_scoreboard;
    cfg_t        settings;
    int unsigned chan_idx;
    int unsigned pos_idx;
    logic [31:0] scale_mult [MAX_CHANNELS];
    logic [5:0]  scale_sh   [MAX_CHANNELS];
    logic [7:0]  zero_pt    [MAX_CHANNELS];
    logic [31:0] slope_mult [MAX_CHANNELS];
    logic [5:0]  slope_sh   [MAX_CHANNELS];
    act_t        acts[$];
    int          errors;
    int          results_seen;

    function new();
      settings.channel_count       = 5'd16;
      settings.positions_per_frame = 22'd1;
      settings.round_mode          = RND_FLOOR;
      settings.prelu_enable        = 1'b0;
      settings.prelu_first         = 1'b0;
      settings.saturate_enable     = 1'b1;
      chan_idx     = 0;
      pos_idx      = 0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return acts.size();
    endfunction

    // multiply by a sign-extended multiplier (64-bit wrap), then shift with rounding
    function logic [63:0] scale_pass(logic [63:0] v, logic [31:0] mult, logic [5:0] sh);
      logic [63:0] prod;
      logic [63:0] mag;
      logic        neg;
      prod = v * {{32{mult[31]}}, mult};
      if (sh == 6'd0) return prod;
      neg = prod[63];
      if (settings.round_mode == RND_FLOOR) return 64'($signed(prod) >>> sh);
      mag = neg ? -prod : prod;
      if (settings.round_mode == RND_NEAREST) mag = mag + (64'd1 << (sh - 6'd1));
      mag = mag >> sh;
      return neg ? -mag : mag;
    endfunction

    function act_t requantize(logic signed [31:0] acc);
      act_t        r;
      logic [63:0] v;
      int unsigned nch;
      int unsigned npos;
      int unsigned ch;
      int unsigned pos;
      logic        last_ch;
      logic        last_pos;
      nch = settings.channel_count;
      if (nch == 0) nch = 1;
      if (nch > MAX_CHANNELS) nch = MAX_CHANNELS;
      npos = settings.positions_per_frame;
      if (npos == 0) npos = 1;
      // counters left past a lowered limit sit on their last value
      ch  = (chan_idx >= nch) ? nch - 1 : chan_idx;
      pos = (pos_idx >= npos) ? npos - 1 : pos_idx;

      v = {{32{acc[31]}}, acc};
      if (settings.prelu_enable && settings.prelu_first && v[63])
        v = scale_pass(v, slope_mult[ch], slope_sh[ch]);
      v = scale_pass(v, scale_mult[ch], scale_sh[ch]);
      v = v + {{56{zero_pt[ch][7]}}, zero_pt[ch]};
      if (settings.prelu_enable && !settings.prelu_first && v[63])
        v = scale_pass(v, slope_mult[ch], slope_sh[ch]);

      if (settings.saturate_enable && $signed(v) > SAT_MAX)      r.activation = 8'sd127;
      else if (settings.saturate_enable && $signed(v) < SAT_MIN) r.activation = -8'sd128;
      else                                                       r.activation = v[7:0];

      last_ch   = (ch + 1 >= nch);
      last_pos  = (pos + 1 >= npos);
      r.channel = ch[3:0];
      r.last    = last_ch && last_pos;
      if (last_ch) begin
        chan_idx = 0;
        pos_idx  = last_pos ? 0 : pos + 1;
      end else begin
        chan_idx = ch + 1;
        pos_idx  = pos;
      end
      return r;
    endfunction

    function void note_item(pcrp_item_t it);
      if (it.command == CMD_LOAD) begin
        scale_mult[it.table_channel] = it.scale_multiplier;
        scale_sh[it.table_channel]   = it.scale_shift;
        zero_pt[it.table_channel]    = it.zero_offset;
        slope_mult[it.table_channel] = it.slope_multiplier;
        slope_sh[it.table_channel]   = it.slope_shift;
      end else begin
        acts.push_back(requantize(it.accumulator));
      end
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= REPORT_CAP) $display("mismatch: %s", what);
    endtask

    task check_act(logic signed [7:0] act, logic [3:0] ch, logic last);
      act_t want;
      results_seen++;
      if (acts.size() == 0) begin
        report_mismatch($sformatf("result %0d unexpected (act %0d ch %0d last %0b)",
                                  results_seen, act, ch, last));
        return;
      end
      want = acts.pop_front();
      if (act !== want.activation)
        report_mismatch($sformatf("result %0d activation %0d, want %0d",
                                  results_seen, act, want.activation));
      if (ch !== want.channel)
        report_mismatch($sformatf("result %0d out_channel %0d, want %0d",
                                  results_seen, ch, want.channel));
      if (last !== want.last)
        report_mismatch($sformatf("result %0d frame_last %0b, want %0b",
                                  results_seen, last, want.last));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pcrp_in_if  in_ch ();
  pcrp_out_if out_ch ();

  requant_scoreboard sb;
  int                burst_left = 0;
  bit                hold_request = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  per_channel_requantize_prelu dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // shifts lean toward the range where products land near int8
  function automatic logic [5:0] shift_pick();
    if ($urandom_range(0, 3) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(46, 62));
  endfunction

  function automatic pcrp_item_t random_item(logic cmd);
    pcrp_item_t it;
    it.command       = cmd;
    it.table_channel = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 7))
      0:       it.accumulator = 32'h7FFF_FFFF;
      1:       it.accumulator = 32'h8000_0000;
      2:       it.accumulator = $urandom_range(0, 65535) - 32768;
      3:       it.accumulator = $urandom_range(0, 2097151) - 1048576;
      default: it.accumulator = $urandom();
    endcase
    it.scale_multiplier = $urandom();
    it.scale_shift      = shift_pick();
    it.zero_offset      = 8'($urandom());
    it.slope_multiplier = $urandom();
    it.slope_shift      = shift_pick();
    return it;
  endfunction

  // present one item and hold it until the block takes it
  task automatic transfer_item(input pcrp_item_t it);
    in_ch.valid            <= 1'b1;
    in_ch.command          <= it.command;
    in_ch.table_channel    <= it.table_channel;
    in_ch.accumulator      <= it.accumulator;
    in_ch.scale_multiplier <= it.scale_multiplier;
    in_ch.scale_shift      <= it.scale_shift;
    in_ch.zero_offset      <= it.zero_offset;
    in_ch.slope_multiplier <= it.slope_multiplier;
    in_ch.slope_shift      <= it.slope_shift;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_item(it);
  endtask

  // burst pacing: a gap of random length between bursts, long bursts now and then
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 18);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  // drop valid, wait for every pending result, then let loads and idle return finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write all six registers back to back, one per edge
  task automatic apply_settings(input cfg_t c);
    cfg_reg_t              idx;
    logic [CFG_DATA_W-1:0] value;
    for (int i = 0; i <= int'(REG_SATURATE); i++) begin
      idx = cfg_reg_t'(i);
      case (idx)
        REG_CHANNEL_COUNT: value = CFG_DATA_W'(c.channel_count);
        REG_POSITIONS:     value = CFG_DATA_W'(c.positions_per_frame);
        REG_ROUND_MODE:    value = CFG_DATA_W'(c.round_mode);
        REG_PRELU_ENABLE:  value = CFG_DATA_W'(c.prelu_enable);
        REG_PRELU_FIRST:   value = CFG_DATA_W'(c.prelu_first);
        default:           value = CFG_DATA_W'(c.saturate_enable);
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= value;
      @(posedge clk);
    end
    cfg_we      <= 1'b0;
    sb.settings = c;
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    pcrp_item_t              it;
    cfg_t                    c;
    logic signed [31:0]      probe_accs [9];
    sb = new();

    rst                    <= 1'b1;
    cfg_we                 <= 1'b0;
    cfg_index              <= '0;
    cfg_data               <= '0;
    in_ch.valid            <= 1'b0;
    in_ch.command          <= CMD_LOAD;
    in_ch.table_channel    <= '0;
    in_ch.accumulator      <= '0;
    in_ch.scale_multiplier <= '0;
    in_ch.scale_shift      <= '0;
    in_ch.zero_offset      <= '0;
    in_ch.slope_multiplier <= '0;
    in_ch.slope_shift      <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: fill every table entry first so no process item ever reads an
    // unwritten entry; channels 0 and 1 carry the field extremes, each with a zero shift
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      it = random_item(CMD_LOAD);
      it.table_channel = 4'(i);
      if (i == 0) begin
        it.scale_multiplier = 32'h7FFF_FFFF;
        it.scale_shift      = 6'd0;
        it.zero_offset      = 8'sh7F;
        it.slope_multiplier = 32'h8000_0000;
        it.slope_shift      = 6'd63;
      end else if (i == 1) begin
        it.scale_multiplier = 32'h8000_0000;
        it.scale_shift      = 6'd63;
        it.zero_offset      = 8'sh80;
        it.slope_multiplier = 32'h7FFF_FFFF;
        it.slope_shift      = 6'd0;
      end
      pace();
      transfer_item(it);
    end

    // directed accumulators at the reset settings: saturation both ways
    probe_accs = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, -32'sd1, 32'sd1,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'sd12345, -32'sd54321};
    foreach (probe_accs[k]) begin
      it = random_item(CMD_PROCESS);
      it.accumulator = probe_accs[k];
      pace();
      transfer_item(it);
    end
    settle();

    for (int phase = 1; phase <= PHASES; phase++) begin
      // first two phases pin the register extremes, the rest draw at random;
      // shrinking the channel count here leaves the counter past its new limit
      case (phase)
        1: begin
          c.channel_count       = 5'd1;
          c.positions_per_frame = 22'h3F_FFFF;
          c.round_mode          = 2'd3;
          c.prelu_enable        = 1'b1;
          c.prelu_first         = 1'b1;
          c.saturate_enable     = 1'b0;
        end
        2: begin
          c.channel_count       = 5'd31;
          c.positions_per_frame = 22'd0;
          c.round_mode          = RND_NEAREST;
          c.prelu_enable        = 1'b1;
          c.prelu_first         = 1'b0;
          c.saturate_enable     = 1'b1;
        end
        default: begin
          case ($urandom_range(0, 5))
            0:       c.channel_count = 5'd0;
            1:       c.channel_count = 5'd1;
            2:       c.channel_count = 5'd16;
            3:       c.channel_count = 5'd31;
            default: c.channel_count = 5'($urandom_range(1, 16));
          endcase
          case ($urandom_range(0, 5))
            0:       c.positions_per_frame = 22'd0;
            1:       c.positions_per_frame = 22'd1;
            2:       c.positions_per_frame = 22'($urandom_range(1, 22'h3F_FFFF));
            default: c.positions_per_frame = 22'($urandom_range(1, 6));
          endcase
          c.round_mode      = 2'($urandom_range(0, 3));
          c.prelu_enable    = ($urandom_range(0, 3) != 0);
          c.prelu_first     = 1'($urandom_range(0, 1));
          c.saturate_enable = 1'($urandom_range(0, 1));
        end
      endcase
      apply_settings(c);

      // ask the receiver for one long hold-off while items keep coming
      if (phase == 1) hold_request = 1'b1;

      repeat (ITEMS_PER_PHASE) begin
        pace();
        transfer_item(random_item(($urandom_range(0, 6) == 0) ? CMD_LOAD : CMD_PROCESS));
      end
      settle();
    end

    if (sb.errors == 0) begin
      $display("per_channel_requantize_prelu regression: pass");
    end else begin
      $display("per_channel_requantize_prelu regression: fail");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // receiver: segments of differing ready density, one long hold on request
  // --------------------------------------------------------------------------
  initial begin
    int seg_len;
    int seg_mode;
    out_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      seg_len  = $urandom_range(10, 80);
      seg_mode = $urandom_range(0, 3);
      if (hold_request) begin
        hold_request = 1'b0;
        seg_len      = LONG_HOLD;
        seg_mode     = 4;
      end
      repeat (seg_len) begin
        @(posedge clk);
        case (seg_mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          2:       out_ch.ready <= 1'($urandom_range(0, 1));
          3:       out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= 1'b0;
        endcase
      end
    end
  end

  // result monitor: every output transfer is checked against the oldest prediction
  always @(posedge clk) begin
    if (rst === 1'b0 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      sb.check_act(out_ch.activation, out_ch.out_channel, out_ch.frame_last);
  end

  // watchdog: too long without any transfer on either channel ends the run
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        idle = 0;
      else
        idle++;
    end
    $display("per_channel_requantize_prelu regression: fail");
    $finish;
  end

endmodule
